/* hw/rtl/detuned_saw_stack_oscillator_defines.svh */
`ifndef DETUNED_SAW_STACK_OSCILLATOR_DEFINES_SVH
`define DETUNED_SAW_STACK_OSCILLATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define DSSO_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define DSSO_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/dsso_pkg.sv */
`timescale 1ns / 1ps

package dsso_pkg;

  // Field and register widths.
  localparam int NOTE_W     = 7;
  localparam int FINE_W     = 8;
  localparam int SAMPLE_W   = 32;
  localparam int PHASE_W    = 32;
  localparam int GAIN_W     = 16;
  localparam int DET_W      = 17;
  localparam int OFF_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // Shared multiplier operand widths. They cover up to sixteen saws, where the
  // mix accumulator needs 52 bits and the mix after the first shift 36 bits.
  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = 33;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 52;

  // Divisor of the fine pitch interpolation.
  localparam logic [7:0] FINE_DIV = 8'hFF;

  // Register reset values.
  localparam logic [DET_W-1:0]  DETUNE_RST = 17'd32768;
  localparam logic [GAIN_W-1:0] CENTER_RST = 16'd45875;
  localparam logic [GAIN_W-1:0] SIDE_RST   = 16'd26214;
  localparam logic [GAIN_W-1:0] OUTPUT_RST = 16'd21140;

  // Saw i starts at i times this spread after reset.
  localparam logic [PHASE_W-1:0] PHASE_SPREAD = 32'h9E3779B9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DETUNE = 2'd0,
    CFG_CENTER = 2'd1,
    CFG_SIDE   = 2'd2,
    CFG_OUTPUT = 2'd3
  } dsso_cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LUT_A,
    ST_LUT_B,
    ST_DIV_SUM,
    ST_DIV_FIX,
    ST_MIX,
    ST_MIX_END,
    ST_GAIN,
    ST_SAT,
    ST_DT_MAG,
    ST_DT_STEP,
    ST_DT_END
  } dsso_state_e;

  typedef struct packed {
    dsso_state_e state;
    logic        first;
  } dsso_ctrl_t;

  // Equal-tempered phase increments. Note 120 sits at the top octave value and
  // each octave below halves it.
  localparam int NOTE_COUNT = 128;
  localparam logic [63:0] TOP_INC = 64'd749115498;
  localparam logic [31:0] SEMI_RATIO [12] = '{
    32'd1073741824, 32'd1137589835, 32'd1205234447, 32'd1276901417,
    32'd1352829926, 32'd1433273380, 32'd1518500250, 32'd1608794974,
    32'd1704458901, 32'd1805811301, 32'd1913190429, 32'd2026954652
  };

  typedef logic [PHASE_W-1:0] note_tab_t [NOTE_COUNT];

  function automatic note_tab_t build_note_table();
    note_tab_t   t;
    logic [63:0] p;
    int          oct;
    int          k;
    for (int n = 0; n < NOTE_COUNT; n++) begin
      oct  = n / 12;
      k    = n % 12;
      p    = TOP_INC * 64'(SEMI_RATIO[k]);
      t[n] = 32'(p >> (40 - oct));
    end
    return t;
  endfunction

  localparam note_tab_t NOTE_STEP_TABLE = build_note_table();

  // Detune offsets in signed Q0.16, split into magnitude and sign.
  // Voices past the seventh have no offset.
  function automatic logic [OFF_W-1:0] offset_mag(logic [3:0] i);
    logic [OFF_W-1:0] m;
    case (i)
      4'd0:    m = 13'd7210;
      4'd1:    m = 13'd4121;
      4'd2:    m = 13'd1279;
      4'd4:    m = 13'd1305;
      4'd5:    m = 13'd4074;
      4'd6:    m = 13'd7042;
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic logic offset_neg(logic [3:0] i);
    logic n;
    case (i)
      4'd0, 4'd1, 4'd2: n = 1'b1;
      default:          n = 1'b0;
    endcase
    return n;
  endfunction

endpackage

/* hw/rtl/dsso_if.sv */
`timescale 1ns / 1ps

interface dsso_in_if import dsso_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [NOTE_W-1:0] note;
  logic [FINE_W-1:0] fine;

  modport source (output valid, output note, output fine, input ready);
  modport sink (input valid, input note, input fine, output ready);
endinterface

interface dsso_out_if import dsso_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

/* hw/rtl/dsso_mul.sv */
`timescale 1ns / 1ps

module dsso_mul import dsso_pkg::*; (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [MUL_A_W-1:0] a_i,
  input  logic signed [MUL_B_W-1:0] b_i,
  output logic signed [MUL_P_W-1:0] p_o
);

  logic signed [MUL_P_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

/* hw/rtl/dsso_seq.sv */
`timescale 1ns / 1ps

module dsso_seq import dsso_pkg::*; #(
  parameter int SAW_COUNT = 7,
  localparam int IDX_W = $clog2(SAW_COUNT)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             out_free_i,
  output dsso_ctrl_t       ctrl_o,
  output logic [IDX_W-1:0] idx_o
);

  dsso_state_e      state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    last    = (idx_q == IDX_W'(SAW_COUNT - 1));
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_LUT_A;
        end
      end
      ST_LUT_A:   state_d = ST_LUT_B;
      ST_LUT_B:   state_d = ST_DIV_SUM;
      ST_DIV_SUM: state_d = ST_DIV_FIX;
      ST_DIV_FIX: begin
        state_d = ST_MIX;
        idx_d   = '0;
      end
      ST_MIX: begin
        if (last) begin
          state_d = ST_MIX_END;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_MIX_END: state_d = ST_GAIN;
      ST_GAIN:    state_d = ST_SAT;
      ST_SAT: begin
        if (out_free_i) begin
          state_d = ST_DT_MAG;
          idx_d   = '0;
        end
      end
      ST_DT_MAG:  state_d = ST_DT_STEP;
      ST_DT_STEP: begin
        if (last) begin
          state_d = ST_DT_END;
        end else begin
          state_d = ST_DT_MAG;
          idx_d   = idx_q + IDX_W'(1);
        end
      end
      ST_DT_END:  state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  assign ctrl_o.state = state_q;
  assign ctrl_o.first = (idx_q == '0);
  assign idx_o        = idx_q;

endmodule

/* hw/rtl/detuned_saw_stack_oscillator.sv */
`timescale 1ns / 1ps
// Detuned saw stack oscillator: SAW_COUNT phase accumulators, each a naive saw,
// mixed with a centre and a side gain, scaled by an output gain and saturated.
// Input channel in_i: one item per audio sample tick, carrying a note number
// and an upward fine step of 1/255 semitone. Output channel out_o: one signed
// Q1.31 sample item for every input item, in order.
// Configuration: cfg_we_i writes cfg_data_i into the register named by
// cfg_idx_i (detune amount, centre gain, side gain, output gain). Write only
// while the block is idle with no sample outstanding.
// Sequencing: all multiplies run through one shared multiplier under a sequencer.
// An accepted item passes through the table lookup and divide by 255, one
// multiply per saw for the mix, and the output gain and saturation into the
// output register, then two multiplies per saw for the detuned phase advance.
// The next item is accepted only once that phase advance is done.
// The output register holds one finished sample. If the receiver stalls, the
// block waits before advancing the phases until that register is free.
// Reset returns the registers to their defaults and the saws to fixed,
// distinct starting phases; the block is ready as soon as reset is released.
module detuned_saw_stack_oscillator import dsso_pkg::*; #(
  parameter int SAW_COUNT    = 7,
  parameter int CENTER_INDEX = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  dsso_in_if.sink               in_i,
  dsso_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int IDX_W = $clog2(SAW_COUNT);

  // Configuration registers.
  logic [DET_W-1:0]  detune_q;
  logic [GAIN_W-1:0] center_q;
  logic [GAIN_W-1:0] side_q;
  logic [GAIN_W-1:0] outgain_q;

  // Sequencer and shared multiplier.
  dsso_ctrl_t                ctrl;
  logic [IDX_W-1:0]          idx;
  logic                      in_accept;
  logic                      out_free;
  logic                      mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;

  // Item registers and datapath.
  logic [NOTE_W-1:0]          note_q;
  logic [FINE_W-1:0]          fine_q;
  logic [NOTE_W-1:0]          next_note;
  logic [NOTE_W-1:0]          tab_idx;
  logic [PHASE_W-1:0]         tab_val;
  logic [PHASE_W-1:0]         a_q;
  logic [39:0]                x_q;
  logic [40:0]                s_q;
  logic [40:0]                s_d;
  logic [31:0]                q_est;
  logic [40:0]                rem;
  logic [PHASE_W-1:0]         inc_q;
  logic [PHASE_W-1:0]         phase_q [SAW_COUNT];
  logic signed [31:0]         saw;
  logic                       is_center;
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [35:0]         mix_scaled;
  logic signed [SAMPLE_W-1:0] sat_val;
  logic [IDX_W-1:0]           wr_idx;
  logic                       phase_we;
  logic [29:0]                detune_m;
  logic [PHASE_W-1:0]         step;
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_sample_q;

  assign in_accept = in_i.valid && in_i.ready;
  assign out_free  = !out_valid_q || out_o.ready;

  dsso_seq #(
    .SAW_COUNT (SAW_COUNT)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_accept),
    .out_free_i (out_free),
    .ctrl_o     (ctrl),
    .idx_o      (idx)
  );

  dsso_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign in_i.ready   = (ctrl.state == ST_IDLE);
  assign out_o.valid  = out_valid_q;
  assign out_o.sample = out_sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      detune_q  <= DETUNE_RST;
      center_q  <= CENTER_RST;
      side_q    <= SIDE_RST;
      outgain_q <= OUTPUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DETUNE: detune_q  <= cfg_data_i;
        CFG_CENTER: center_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_SIDE:   side_q    <= cfg_data_i[GAIN_W-1:0];
        CFG_OUTPUT: outgain_q <= cfg_data_i[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The top note interpolates toward itself, so fine has no effect there.
  assign next_note = (note_q == {NOTE_W{1'b1}}) ? note_q : note_q + NOTE_W'(1);
  assign tab_idx   = (ctrl.state == ST_LUT_A) ? note_q : next_note;
  assign tab_val   = NOTE_STEP_TABLE[tab_idx];

  // Divide by 255: the sum x * (1 + 2^-8 + ... + 2^-32) / 256 lands on the true
  // quotient or one below it, and the remainder check fixes the latter case.
  assign s_d = 41'(mul_p[39:0]) + 41'(mul_p[39:8]) + 41'(mul_p[39:16])
             + 41'(mul_p[39:24]) + 41'(mul_p[39:32]);
  assign q_est = s_q[39:8];
  assign rem   = 41'(x_q) - {1'b0, q_est, 8'd0} + 41'(q_est);

  // A saw reads as 2 * phase - 1 in Q1.31, which is the phase with its top bit flipped.
  assign saw       = {~phase_q[idx][PHASE_W-1], phase_q[idx][PHASE_W-2:0]};
  assign is_center = (int'(idx) == CENTER_INDEX);

  // Multiplier operand selection for each sequencer step.
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (ctrl.state)
      ST_LUT_B: begin
        mul_a = MUL_A_W'(fine_q);
        mul_b = {1'b0, tab_val - a_q};
      end
      ST_MIX: begin
        mul_a = MUL_A_W'(saw);
        mul_b = MUL_B_W'(is_center ? center_q : side_q);
      end
      ST_GAIN: begin
        mul_a = acc_q[ACC_W-1:16];
        mul_b = MUL_B_W'(outgain_q);
      end
      ST_DT_MAG: begin
        mul_a = MUL_A_W'(offset_mag(4'(idx)));
        mul_b = MUL_B_W'(detune_q);
      end
      ST_DT_STEP: begin
        mul_a = MUL_A_W'(mul_p[29:0]);
        mul_b = {1'b0, inc_q};
      end
      default: mul_en = 1'b0;
    endcase
  end

  // Mixed sample after the output gain, floor-shifted and clamped to Q1.31.
  assign mix_scaled = mul_p[ACC_W-1:16];
  always_comb begin
    if (mix_scaled[35:31] == 5'b00000 || mix_scaled[35:31] == 5'b11111) begin
      sat_val = mix_scaled[SAMPLE_W-1:0];
    end else if (mix_scaled[35]) begin
      sat_val = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      note_q <= in_i.note;
      fine_q <= in_i.fine;
    end
    if (ctrl.state == ST_LUT_A) begin
      a_q <= tab_val;
    end
    if (ctrl.state == ST_DIV_SUM) begin
      x_q <= mul_p[39:0];
      s_q <= s_d;
    end
    if (ctrl.state == ST_DIV_FIX) begin
      inc_q <= a_q + q_est + 32'(rem >= 41'(FINE_DIV));
    end
    if (ctrl.state == ST_MIX && ctrl.first) begin
      acc_q <= '0;
    end else if (ctrl.state == ST_MIX || ctrl.state == ST_MIX_END) begin
      acc_q <= acc_q + ACC_W'(signed'(mul_p[47:0]));
    end
  end

  // The step product of a saw arrives while the next saw starts its detune
  // magnitude, so the write trails the sequencer index by one.
  assign phase_we = (ctrl.state == ST_DT_MAG && !ctrl.first) || (ctrl.state == ST_DT_END);
  assign wr_idx   = (ctrl.state == ST_DT_END) ? idx : idx - IDX_W'(1);
  assign detune_m = mul_p[61:32];
  assign step     = offset_neg(4'(wr_idx)) ? inc_q - PHASE_W'(detune_m)
                                           : inc_q + PHASE_W'(detune_m);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SAW_COUNT; i++) begin
        phase_q[i] <= PHASE_SPREAD * PHASE_W'(i);
      end
    end else if (phase_we) begin
      phase_q[wr_idx] <= phase_q[wr_idx] + step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.state == ST_SAT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.state == ST_SAT && out_free) begin
      out_sample_q <= sat_val;
    end
  end

endmodule

/* hw/rtl/dsso_chk.sv */
`timescale 1ns / 1ps
`include "detuned_saw_stack_oscillator_defines.svh"

module dsso_chk import dsso_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [SAMPLE_W-1:0] out_sample_i
);

  // After taking an item the block stays busy rather than taking another at once.
  `DSSO_ASSERT_NXT(busy_after_item, in_valid_i && in_ready_i, !in_ready_i ##1 !in_ready_i, "input ready too soon after an item")

  // A new sample only appears while an item is in work.
  `DSSO_ASSERT_IMP(sample_while_busy, $rose(out_valid_i), !in_ready_i, "sample produced while idle")

  // A stalled sample holds its value.
  `DSSO_ASSERT_NXT(sample_held, out_valid_i && !out_ready_i, out_valid_i && $stable(out_sample_i), "stalled sample changed")

endmodule

bind detuned_saw_stack_oscillator dsso_chk u_dsso_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_sample_i (out_o.sample)
);
